### design/slipdec_pkg.sv
// ----------------------------------------------------------------------------
// slipdec_pkg
// Shared SLIP codes, controller states and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package slipdec_pkg;

  localparam logic [7:0] SLIP_END     = 8'o300;
  localparam logic [7:0] SLIP_ESC     = 8'o333;
  localparam logic [7:0] SLIP_ESC_END = 8'o334;
  localparam logic [7:0] SLIP_ESC_ESC = 8'o335;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_READ,
    ST_SHOW
  } slipdec_state_t;

  typedef struct packed {
    logic take;    // receive byte accepted this cycle
    logic read;    // fetch packet byte at the drain index
    logic step;    // current byte delivered, more to come
    logic finish;  // final byte delivered, release the buffer
  } slipdec_cmd_t;

  typedef struct packed {
    logic close_pkt;  // byte on the input is an unescaped END with data buffered
    logic last;       // drain index points at the final buffered byte
  } slipdec_status_t;

endpackage

### design/slipdec_ctrl.sv
// ----------------------------------------------------------------------------
// slipdec_ctrl
// Controller: receive bytes, then drain a closed packet one byte at a time.
// ----------------------------------------------------------------------------
module slipdec_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rx_valid,
  output logic                     rx_ready,
  output logic                     packet_valid,
  input  logic                     packet_ready,
  input  slipdec_pkg::slipdec_status_t status,
  output slipdec_pkg::slipdec_cmd_t    cmd
);
  import slipdec_pkg::*;

  slipdec_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV: begin
        if (rx_valid && status.close_pkt) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (packet_ready) begin
          state_next = status.last ? ST_RECV : ST_READ;
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

  always_comb begin
    rx_ready     = (state == ST_RECV);
    packet_valid = (state == ST_SHOW);
    cmd.take     = (state == ST_RECV) && rx_valid;
    cmd.read     = (state == ST_READ);
    cmd.step     = (state == ST_SHOW) && packet_ready && !status.last;
    cmd.finish   = (state == ST_SHOW) && packet_ready && status.last;
  end

endmodule

### design/slipdec_dpath.sv
// ----------------------------------------------------------------------------
// slipdec_dpath
// Datapath: escape decoding, packet buffer, fill count and drain index.
// ----------------------------------------------------------------------------
module slipdec_dpath #(
  parameter int MAX_PACKET = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               rx_byte,
  input  slipdec_pkg::slipdec_cmd_t    cmd,
  output slipdec_pkg::slipdec_status_t status,
  output logic [7:0]               packet_byte,
  output logic                     is_last,
  output logic                     truncated
);
  import slipdec_pkg::*;

  localparam int IDX_W = $clog2(MAX_PACKET);
  localparam int CNT_W = $clog2(MAX_PACKET + 1);

  logic [7:0]       mem [MAX_PACKET];
  logic [7:0]       rd_data;
  logic             escape_pending, escape_pending_next;
  logic             overflow_seen, overflow_seen_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [7:0]       dec_byte;
  logic             store, is_close, wr_en, full;

  assign full = (fill_count == CNT_W'(MAX_PACKET));

  // Classify the incoming byte.
  always_comb begin
    dec_byte = rx_byte;
    store    = 1'b0;
    is_close = 1'b0;
    escape_pending_next = escape_pending;
    if (escape_pending) begin
      if (rx_byte == SLIP_ESC_END) begin
        dec_byte = SLIP_END;
      end else if (rx_byte == SLIP_ESC_ESC) begin
        dec_byte = SLIP_ESC;
      end
      store = 1'b1;
      escape_pending_next = 1'b0;
    end else if (rx_byte == SLIP_END) begin
      is_close = 1'b1;
    end else if (rx_byte == SLIP_ESC) begin
      escape_pending_next = 1'b1;
    end else begin
      store = 1'b1;
    end
  end

  assign wr_en            = cmd.take && store && !full;
  assign status.close_pkt = is_close && (fill_count != '0);
  assign status.last      = ((CNT_W'(rd_idx) + CNT_W'(1)) == fill_count);

  always_comb begin
    fill_count_next    = fill_count;
    overflow_seen_next = overflow_seen;
    rd_idx_next        = rd_idx;
    if (cmd.take) begin
      if (wr_en) begin
        fill_count_next = fill_count + CNT_W'(1);
      end else if (store) begin
        overflow_seen_next = 1'b1;
      end
      // Drop empty packets, but forget any overflow.
      if (is_close && fill_count == '0) begin
        overflow_seen_next = 1'b0;
      end
      if (is_close) begin
        rd_idx_next = '0;
      end
    end
    if (cmd.step) begin
      rd_idx_next = rd_idx + IDX_W'(1);
    end
    if (cmd.finish) begin
      fill_count_next    = '0;
      overflow_seen_next = 1'b0;
      rd_idx_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      overflow_seen  <= 1'b0;
      fill_count     <= '0;
      rd_idx         <= '0;
    end else begin
      if (cmd.take) begin
        escape_pending <= escape_pending_next;
      end
      overflow_seen <= overflow_seen_next;
      fill_count    <= fill_count_next;
      rd_idx        <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_count[IDX_W-1:0]] <= dec_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= mem[rd_idx];
    end
  end

  assign packet_byte = rd_data;
  assign is_last     = status.last;
  assign truncated   = overflow_seen;

endmodule

### design/slip_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder_unit
// SLIP receive decoder: unstuffs serial-line bytes into buffered packets.
// ----------------------------------------------------------------------------
// Bytes arrive one item per cycle on rx_*, and the block takes one every
// cycle while it is receiving. ESC followed by ESC_END or ESC_ESC yields END
// or ESC; ESC followed by any other byte stores that byte as is. An
// unescaped END closes the packet: an empty packet is dropped, otherwise the
// buffered bytes are sent on packet_* in order, is_last marking the final
// one and truncated set on every byte when more than MAX_PACKET bytes came
// in (the extra ones are dropped). While a packet drains, rx_ready is low.
// Each output byte is read from the packet buffer in the read state and
// then presented from the registered data in the show state, so reception
// stays held off until the whole packet has drained, stalls on packet_ready included.
// ----------------------------------------------------------------------------
module slip_frame_decoder_unit #(
  parameter int MAX_PACKET = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       packet_valid,
  input  logic       packet_ready,
  output logic [7:0] packet_byte,
  output logic       is_last,
  output logic       truncated
);
  import slipdec_pkg::*;

  slipdec_cmd_t    cmd;
  slipdec_status_t status;

  // Sequence receive and drain phases.
  slipdec_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .packet_valid (packet_valid),
    .packet_ready (packet_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Decode escapes, hold the packet buffer and walk it on drain.
  slipdec_dpath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .status      (status),
    .packet_byte (packet_byte),
    .is_last     (is_last),
    .truncated   (truncated)
  );

endmodule

### design/slipdec_checker.sv
// ----------------------------------------------------------------------------
// slipdec_checker
// Port-level checks for the SLIP decoder, bound to the top level.
// ----------------------------------------------------------------------------
module slipdec_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic [7:0] rx_byte,
  input logic       packet_valid,
  input logic       packet_ready,
  input logic [7:0] packet_byte,
  input logic       is_last,
  input logic       truncated
);

  // Stalled output holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    packet_valid && !packet_ready |=>
      packet_valid && $stable(packet_byte) && $stable(is_last) && $stable(truncated))
    else $error("output payload changed while stalled");

  // Reception and drain never overlap.
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(rx_ready && packet_valid))
    else $error("rx_ready high during drain");

  // Last byte taken returns the block to reception.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    packet_valid && packet_ready && is_last |=> !packet_valid && rx_ready)
    else $error("drain did not end after last byte");

  // Inner byte taken: a read state with no valid output, then the next byte with the same flag.
  a_next_byte: assert property (@(posedge clk) disable iff (rst)
    packet_valid && packet_ready && !is_last |=>
      !packet_valid ##1 (packet_valid && truncated == $past(truncated, 2)))
    else $error("packet drain broke off early");

endmodule

bind slip_frame_decoder_unit slipdec_checker u_slipdec_checker (.*);
